// ===== rtl/core/gla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gla_pkg: shared types and constants
// Operand and result widths, operation codes and the divider request/response.
// ----------------------------------------------------------------------------
package gla_pkg;

    localparam int OPW  = 16;
    localparam int RESW = 33;
    localparam int MODW = 3;
    localparam int CNTW = $clog2(OPW + 1);

    localparam logic [MODW-1:0] MODE_GCD = 3'd0;
    localparam logic [MODW-1:0] MODE_LCM = 3'd1;
    localparam logic [MODW-1:0] MODE_ADD = 3'd2;
    localparam logic [MODW-1:0] MODE_SUB = 3'd3;
    localparam logic [MODW-1:0] MODE_MUL = 3'd4;
    localparam logic [MODW-1:0] MODE_DIV = 3'd5;

    typedef struct packed {
        logic           start;
        logic [OPW-1:0] dividend;
        logic [OPW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [OPW-1:0] quotient;
        logic [OPW-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/core/gla_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gla_div: restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module gla_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gla_pkg::div_req_t req,
    output gla_pkg::div_rsp_t rsp
);
    import gla_pkg::*;

    logic [OPW-1:0]  rem_reg;
    logic [OPW-1:0]  quo_reg;
    logic [OPW-1:0]  dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [OPW:0]    rem_sh;
    logic [OPW:0]    trial;

    assign rem_sh = {rem_reg, quo_reg[OPW-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(OPW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[OPW])
            begin
                rem_reg <= trial[OPW-1:0];
                quo_reg <= {quo_reg[OPW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[OPW-1:0];
                quo_reg <= {quo_reg[OPW-2:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/core/gcd_lcm_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_arithmetic_unit: GCD, LCM and basic integer arithmetic
// Sequenced around one shared restoring divider and one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one request item; s_tuser carries the operation code,
//   s_tdata the two 16-bit unsigned operands. Output stream m_*: one item per
//   request; m_tdata holds the 33-bit signed result, m_tuser the error flag.
//   s_tready is high only while the sequencer is idle; one request at a time.
// Sequence, accept to result valid:
//   add, subtract, error cases: straight to the result load; multiply:
//   through the multiply state first; divide: issue, one divider pass, load;
//   gcd: one full divider pass per Euclid step (up to 23 steps for 16-bit
//   inputs); lcm: gcd, then a division by the gcd and a multiply.
//   The divider produces one quotient bit per cycle.
// Reset clears the sequencer and the output valid; no request is held.
// A stalled result stays in the output register; a finished computation
//   waits until that register is free, and the next request is taken after.
// ----------------------------------------------------------------------------
module gcd_lcm_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_a [15:0], operand_b [31:16]
    input  logic [2:0]  s_tuser,   // mode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result [32:0], zero fill [39:33]
    output logic [0:0]  m_tuser    // error [0]
);
    import gla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GWAIT,
        S_ISSUE,
        S_QWAIT,
        S_MUL,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [MODW-1:0] mode_reg, mode_next;
    logic [OPW-1:0]  a_reg, a_next;
    logic [OPW-1:0]  b_reg, b_next;
    logic [OPW-1:0]  x_reg, x_next;
    logic [OPW-1:0]  y_reg, y_next;
    logic [RESW-1:0] res_reg, res_next;
    logic            err_reg, err_next;
    logic            mv_reg, mv_next;
    logic [39:0]     md_reg, md_next;
    logic            me_reg, me_next;

    logic [OPW-1:0]   in_a;
    logic [OPW-1:0]   in_b;
    logic [MODW-1:0]  in_mode;
    logic             s_acc;
    logic [2*OPW-1:0] prod;
    div_req_t         dreq;
    div_rsp_t         drsp;

    assign in_a    = s_tdata[OPW-1:0];
    assign in_b    = s_tdata[2*OPW-1:OPW];
    assign in_mode = s_tuser;
    assign s_acc   = s_tvalid && s_tready;
    assign prod    = x_reg * y_reg;

    assign dreq.start    = (state_reg == S_ISSUE) ||
                           ((state_reg == S_GCD) && (y_reg != '0));
    assign dreq.dividend = x_reg;
    assign dreq.divisor  = y_reg;

    gla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        res_next   = res_reg;
        err_next   = err_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        me_next    = me_reg;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    mode_next  = in_mode;
                    a_next     = in_a;
                    b_next     = in_b;
                    x_next     = in_a;
                    y_next     = in_b;
                    res_next   = '0;
                    err_next   = 1'b0;
                    state_next = S_DONE;
                    unique case (in_mode)
                        MODE_GCD, MODE_LCM:
                        begin
                            if (in_a == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_GCD;
                            end
                        end
                        MODE_ADD:
                        begin
                            res_next = {{(RESW-OPW){1'b0}}, in_a} +
                                       {{(RESW-OPW){1'b0}}, in_b};
                        end
                        MODE_SUB:
                        begin
                            res_next = {{(RESW-OPW){1'b0}}, in_a} -
                                       {{(RESW-OPW){1'b0}}, in_b};
                        end
                        MODE_MUL:
                        begin
                            state_next = S_MUL;
                        end
                        MODE_DIV:
                        begin
                            if (in_b == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
            end
            S_GCD:
            begin
                if (y_reg != '0)
                begin
                    state_next = S_GWAIT;
                end
                else if (mode_reg == MODE_GCD)
                begin
                    res_next   = {{(RESW-OPW){1'b0}}, x_reg};
                    state_next = S_DONE;
                end
                else
                begin
                    x_next     = a_reg;
                    y_next     = x_reg;
                    state_next = S_ISSUE;
                end
            end
            S_GWAIT:
            begin
                if (drsp.done)
                begin
                    x_next     = y_reg;
                    y_next     = drsp.remainder;
                    state_next = S_GCD;
                end
            end
            S_ISSUE:
            begin
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (drsp.done)
                begin
                    if (mode_reg == MODE_LCM)
                    begin
                        x_next     = drsp.quotient;
                        y_next     = b_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_next   = {{(RESW-OPW){1'b0}}, drsp.quotient};
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL:
            begin
                res_next   = {{(RESW-2*OPW){1'b0}}, prod};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {{(40-RESW){1'b0}}, res_reg};
                    me_next    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        res_reg  <= res_next;
        err_reg  <= err_next;
        md_reg   <= md_next;
        me_reg   <= me_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = me_reg;

endmodule

// ===== rtl/core/gla_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gla_chk: port-level checks
// Watches the top level's streams over time; attached by bind.
// ----------------------------------------------------------------------------
module gla_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a held result keeps its valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // a held result keeps its data
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // an error item carries a zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 40'd0)
        else $error("error item with nonzero result");

endmodule

bind gcd_lcm_arithmetic_unit gla_chk u_gla_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gcd_lcm_arithmetic_unit
// Sends directed corner requests, then weighted random ones, over phases of
// sender idling and receiver stalling. Each request's answer is predicted
// here and compared in order with the result stream.
// ----------------------------------------------------------------------------
module tb;

    import gla_pkg::*;

    localparam logic [MODW-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODW-1:0] MODE_UNUSED_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 60;

    typedef struct {
        logic [MODW-1:0] mode;
        logic [OPW-1:0]  a;
        logic [OPW-1:0]  b;
    } request_t;

    typedef struct {
        logic [RESW-1:0] value;
        logic            err;
    } answer_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // operand_a [15:0], operand_b [31:16]
    logic [2:0]  s_tuser = '0;   // mode [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // result [32:0], zero fill [39:33]
    logic [0:0]  m_tuser;        // error [0]

    request_t queued_requests[$];
    answer_t  expected_answers[$];
    request_t next_request;
    answer_t  due;

    logic request_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   requests_pushed = 0;
    int   requests_taken = 0;
    int   answers_checked = 0;
    int   errors_flagged = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   mode_seen[8];

    gcd_lcm_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic answer_t compute_answer(logic [MODW-1:0] mode, logic [OPW-1:0] a,
                                               logic [OPW-1:0] b);
        answer_t         ans;
        logic [RESW-1:0] wa;
        logic [RESW-1:0] wb;
        logic [RESW-1:0] x;
        logic [RESW-1:0] y;
        logic [RESW-1:0] r;
        wa = RESW'(a);
        wb = RESW'(b);
        x = wa;
        y = wb;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        ans.value = '0;
        ans.err = 1'b0;
        case (mode)
            MODE_GCD:
                if (a == '0) ans.err = 1'b1;
                else ans.value = x;
            MODE_LCM:
                if (a == '0) ans.err = 1'b1;
                else ans.value = (wa / x) * (wb / x) * x;
            MODE_ADD: ans.value = wa + wb;
            MODE_SUB: ans.value = wa - wb;
            MODE_MUL: ans.value = wa * wb;
            MODE_DIV:
                if (b == '0) ans.err = 1'b1;
                else ans.value = wa / wb;
            default: ans.err = 1'b1;
        endcase
        return ans;
    endfunction

    task automatic add_request(logic [MODW-1:0] mode, logic [OPW-1:0] a, logic [OPW-1:0] b);
        request_t req;
        req.mode = mode;
        req.a = a;
        req.b = b;
        queued_requests.push_back(req);
        requests_pushed++;
    endtask

    task automatic add_random_request();
        logic [MODW-1:0] mode;
        logic [OPW-1:0]  a;
        logic [OPW-1:0]  b;
        int              g;
        if ($urandom_range(99) < 4) mode = MODW'($urandom_range(7, 6));
        else mode = MODW'($urandom_range(5, 0));
        a = OPW'($urandom);
        b = OPW'($urandom);
        case ($urandom_range(9))
            4:
            begin
                a = OPW'($urandom_range(15));
                b = OPW'($urandom_range(15));
            end
            5:
            begin
                g = $urandom_range(255, 1);
                a = OPW'(g * $urandom_range(255, 1));
                b = OPW'(g * $urandom_range(255));
            end
            6:
                if ($urandom_range(1)) a = '0;
                else b = '0;
            7:
                if ($urandom_range(1)) a = '1;
                else b = '1;
            8: b = a;
            9: b = OPW'($urandom_range(16, 1));
            default: ;
        endcase
        add_request(mode, a, b);
    endtask

    task automatic drain();
        while (!(requests_taken == requests_pushed && expected_answers.size() == 0))
            @(negedge clk);
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int count, bit long_hold);
        send_idle_pct = tx_pct;
        recv_stall_pct = rx_pct;
        if (long_hold)
            hold_req++;
        for (int i = 0; i < count; i++)
            add_random_request();
        drain();
    endtask

    // drive requests
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || request_taken)
        begin
            if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_request = queued_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_request.mode;
                s_tdata <= {next_request.b, next_request.a};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // drive result back-pressure
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (!rst_n)
            request_taken <= 1'b0;
        else
        begin
            request_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(compute_answer(s_tuser, s_tdata[15:0], s_tdata[31:16]));
                mode_seen[s_tuser]++;
                requests_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t tb: unexpected result, expected none, got %0d err %0b", $time,
                             $signed(m_tdata[32:0]), m_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    due = expected_answers.pop_front();
                    answers_checked++;
                    if (m_tuser[0])
                        errors_flagged++;
                    if (m_tdata[32:0] !== due.value)
                    begin
                        $display("%0t tb: result mismatch, expected %0d, got %0d", $time,
                                 $signed(due.value), $signed(m_tdata[32:0]));
                        mismatches++;
                    end
                    if (m_tuser[0] !== due.err)
                    begin
                        $display("%0t tb: error flag mismatch, expected %0b, got %0b", $time,
                                 due.err, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata[39:33] !== '0)
                    begin
                        $display("%0t tb: fill bits mismatch, expected 0, got %0h", $time,
                                 m_tdata[39:33]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t tb: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        foreach (mode_seen[i])
            mode_seen[i] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_request(MODE_GCD, 16'd0, 16'd5);
        add_request(MODE_GCD, 16'd0, 16'd0);
        add_request(MODE_GCD, 16'd12, 16'd0);
        add_request(MODE_GCD, 16'hFFFF, 16'hFFFF);
        add_request(MODE_GCD, 16'd46368, 16'd28657);
        add_request(MODE_GCD, 16'd48, 16'd18);
        add_request(MODE_LCM, 16'd0, 16'd7);
        add_request(MODE_LCM, 16'd9, 16'd0);
        add_request(MODE_LCM, 16'hFFFF, 16'hFFFE);
        add_request(MODE_LCM, 16'd46368, 16'd28657);
        add_request(MODE_LCM, 16'd12, 16'd18);
        add_request(MODE_ADD, 16'd0, 16'd0);
        add_request(MODE_ADD, 16'hFFFF, 16'hFFFF);
        add_request(MODE_SUB, 16'd0, 16'hFFFF);
        add_request(MODE_SUB, 16'hFFFF, 16'd0);
        add_request(MODE_SUB, 16'd5, 16'd5);
        add_request(MODE_MUL, 16'hFFFF, 16'hFFFF);
        add_request(MODE_MUL, 16'd0, 16'hFFFF);
        add_request(MODE_DIV, 16'd100, 16'd0);
        add_request(MODE_DIV, 16'd0, 16'd0);
        add_request(MODE_DIV, 16'hFFFF, 16'd1);
        add_request(MODE_DIV, 16'd7, 16'hFFFF);
        add_request(MODE_DIV, 16'hFFFF, 16'd255);
        add_request(MODE_UNUSED_6, 16'd3, 16'd4);
        add_request(MODE_UNUSED_7, 16'hFFFF, 16'hFFFF);
        drain();

        run_phase(0, 0, 250, 1'b1);
        run_phase(84, 0, 250, 1'b0);
        run_phase(0, 84, 250, 1'b0);
        run_phase(37, 37, 250, 1'b0);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d requests, %0d results checked, %0d answered with the error flag",
                 requests_taken, answers_checked, errors_flagged);
        $display("tb: gcd %0d lcm %0d add %0d sub %0d mul %0d div %0d unused %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
                 mode_seen[5], mode_seen[6] + mode_seen[7]);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
